// ===== src/rilp_pkg.sv =====
// shared types and constants for the radix integer literal parser
// no dependencies
`timescale 1ns / 1ps

package rilp_pkg;

   localparam int unsigned CH_W     = 8;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned COUNT_W  = 8;
   localparam int unsigned MAG_W    = 31;
   localparam int unsigned RADIX_W  = 5;
   localparam int unsigned DIGIT_W  = 6;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [RADIX_W-1:0] RADIX_BIN = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_OCT = 5'd8;
   localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_HEX = 5'd16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   // classified character word passed from front to back
   typedef struct packed {
      logic                 start;
      logic                 sign;
      logic                 minus;
      logic                 zero;
      logic                 pfx_valid;
      logic [RADIX_W-1:0]   pfx_radix;
      logic                 dvalid;
      logic [DIGIT_W-1:0]   digit;
   } class_type;

endpackage

// ===== src/rilp_front.sv =====
// front end: classifies each incoming character word
// depends on rilp_pkg
`timescale 1ns / 1ps

module rilp_front (
   input  logic [rilp_pkg::CH_W-1:0] ch,
   input  logic                      starts_literal,
   input  logic                      source_end,
   output rilp_pkg::class_type       cls
);
   import rilp_pkg::*;

   logic          is_num;
   logic          is_lower;
   logic          is_upper;
   logic [CH_W-1:0] lc;

   always_comb begin
      is_num   = (ch >= 8'h30) && (ch <= 8'h39);
      is_lower = (ch >= 8'h61) && (ch <= 8'h7a);
      is_upper = (ch >= 8'h41) && (ch <= 8'h5a);
      lc       = is_upper ? ch + 8'd32 : ch;

      cls.start = starts_literal;
      cls.sign  = !source_end && ((ch == 8'h2b) || (ch == 8'h2d));
      cls.minus = !source_end && (ch == 8'h2d);
      cls.zero  = !source_end && (ch == 8'h30);

      cls.pfx_valid = !source_end;
      priority if (lc == 8'h78) begin
         cls.pfx_radix = RADIX_HEX;
      end else if (lc == 8'h62) begin
         cls.pfx_radix = RADIX_BIN;
      end else if (lc == 8'h6f) begin
         cls.pfx_radix = RADIX_OCT;
      end else begin
         cls.pfx_radix = RADIX_DEC;
         cls.pfx_valid = 1'b0;
      end

      cls.dvalid = !source_end && (is_num || is_lower || is_upper);
      priority if (is_num) begin
         cls.digit = DIGIT_W'(ch - 8'h30);
      end else if (is_lower) begin
         cls.digit = DIGIT_W'(ch - 8'h61 + 8'd10);
      end else if (is_upper) begin
         cls.digit = DIGIT_W'(ch - 8'h41 + 8'd10);
      end else begin
         cls.digit = '0;
      end
   end

endmodule

// ===== src/rilp_queue.sv =====
// short queue of classified words between front and back
// depends on rilp_pkg
`timescale 1ns / 1ps

module rilp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rilp_pkg::class_type push_word,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output rilp_pkg::class_type pop_word
);
   import rilp_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   class_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_word  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== src/rilp_back.sv =====
// back end: literal state machine, accumulator and result register
// depends on rilp_pkg
`timescale 1ns / 1ps

module rilp_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               word_valid,
   input  rilp_pkg::class_type                word,
   output logic                               word_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_status,
   output logic signed [rilp_pkg::VALUE_W-1:0] rsp_value,
   output logic [rilp_pkg::COUNT_W-1:0]       rsp_consumed
);
   import rilp_pkg::*;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_FIRST  = 3'd1;
   localparam logic [2:0] PH_BODY   = 3'd2;
   localparam logic [2:0] PH_ZERO   = 3'd3;
   localparam logic [2:0] PH_PREFIX = 3'd4;
   localparam logic [2:0] PH_DIGITS = 3'd5;

   localparam int unsigned PROD_W = MAG_W + RADIX_W;

   logic [2:0]          phase_ff, phase_in;
   logic [RADIX_W-1:0]  radix_ff, radix_in;
   logic [MAG_W-1:0]    acc_ff, acc_in;
   logic                neg_ff, neg_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;

   logic                rsp_valid_ff;
   logic                status_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [COUNT_W-1:0]  consumed_ff;

   logic [MAG_W-1:0]    acc_base;
   logic [RADIX_W-1:0]  radix_base;
   logic [PROD_W-1:0]   next_mag;
   logic                done;
   logic                emit;
   logic                bad;
   logic [VALUE_W-1:0]  mag_ext;

   function automatic logic [COUNT_W-1:0] count_one(input logic [COUNT_W-1:0] c);
      return (c == COUNT_MAX) ? c : c + 1'b1;
   endfunction

   assign word_pop     = word_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_value    = value_ff;
   assign rsp_consumed = consumed_ff;

   assign acc_base   = word.start ? '0 : acc_ff;
   assign radix_base = word.start ? RADIX_DEC : radix_ff;
   assign next_mag   = PROD_W'(acc_base) * PROD_W'(radix_base) + PROD_W'(word.digit);

   always_comb begin
      phase_in = phase_ff;
      radix_in = radix_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      done     = 1'b0;
      emit     = 1'b0;
      bad      = 1'b0;

      if (word.start) begin
         phase_in = PH_FIRST;
         radix_in = RADIX_DEC;
         acc_in   = '0;
         neg_in   = 1'b0;
         cnt_in   = '0;
      end

      if (phase_in == PH_IDLE || phase_in > PH_DIGITS) begin
         done = 1'b1;
      end

      if (!done && phase_in == PH_FIRST) begin
         phase_in = PH_BODY;
         if (word.sign) begin
            neg_in = word.minus;
            cnt_in = count_one(cnt_in);
            done   = 1'b1;
         end
      end

      if (!done && phase_in == PH_BODY) begin
         if (word.zero) begin
            cnt_in   = count_one(cnt_in);
            phase_in = PH_ZERO;
            done     = 1'b1;
         end else begin
            phase_in = PH_DIGITS;
         end
      end

      if (!done && phase_in == PH_ZERO) begin
         if (word.pfx_valid) begin
            radix_in = word.pfx_radix;
            cnt_in   = count_one(cnt_in);
            phase_in = PH_PREFIX;
            done     = 1'b1;
         end else begin
            phase_in = PH_DIGITS;
         end
      end

      if (!done && phase_in == PH_PREFIX) begin
         if (!word.dvalid) begin
            emit = 1'b1;
            bad  = 1'b1;
            done = 1'b1;
         end else begin
            phase_in = PH_DIGITS;
         end
      end

      if (!done) begin
         priority if (!word.dvalid) begin
            emit = 1'b1;
         end else if (word.digit >= DIGIT_W'(radix_base)) begin
            emit = 1'b1;
            bad  = 1'b1;
         end else if (next_mag[PROD_W-1:MAG_W] != '0) begin
            emit = 1'b1;
            bad  = 1'b1;
         end else begin
            acc_in = next_mag[MAG_W-1:0];
            cnt_in = count_one(cnt_in);
         end
      end

      if (emit) begin
         phase_in = PH_IDLE;
      end
   end

   assign mag_ext = VALUE_W'(acc_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         radix_ff     <= RADIX_DEC;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (word_pop) begin
            phase_ff <= phase_in;
            radix_ff <= radix_in;
            acc_ff   <= acc_in;
            neg_ff   <= neg_in;
            cnt_ff   <= cnt_in;
         end
         if (word_pop && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result word, loaded only when the output slot is free or draining
   always_ff @(posedge clock) begin
      if (word_pop && emit) begin
         status_ff   <= bad ? STATUS_BAD : STATUS_OK;
         value_ff    <= bad ? '0 : (neg_in ? (~mag_ext + 1'b1) : mag_ext);
         consumed_ff <= cnt_in;
      end
   end

endmodule

// ===== src/radix_integer_literal_parser_unit.sv =====
// Radix-prefixed integer literal parser, one character word per cycle unless
// stalled. A literal opens on a word flagged starts_literal and takes an optional
// sign, an optional 0x/0b/0o prefix and digits of that base; it closes on the
// first non-alphanumeric character, source end, a digit outside its base or an
// overflow, which yields one result word (status, value, consumed). The back end
// does one 31x5 multiply-add with an overflow check per character, so a new word
// is accepted every cycle unless the result slot stalls. A two-word queue after
// the classifier and a registered result slot let both sides stall independently;
// with the queue empty, a terminator passes the queue and the result register.
// depends on rilp_pkg, rilp_front, rilp_queue, rilp_back
`timescale 1ns / 1ps

module radix_integer_literal_parser_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rilp_pkg::CH_W-1:0]           req_ch,
   input  logic                                req_starts_literal,
   input  logic                                req_source_end,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_status,
   output logic signed [rilp_pkg::VALUE_W-1:0] rsp_value,
   output logic [rilp_pkg::COUNT_W-1:0]        rsp_consumed
);
   import rilp_pkg::*;

   class_type cls;
   class_type q_word;
   logic      q_full;
   logic      q_not_empty;
   logic      q_pop;

   assign req_stall = q_full;

   rilp_front u_front (
      .ch             (req_ch),
      .starts_literal (req_starts_literal),
      .source_end     (req_source_end),
      .cls            (cls)
   );

   rilp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_word (cls),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_word  (q_word)
   );

   rilp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .word_valid   (q_not_empty),
      .word         (q_word),
      .word_pop     (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_value    (rsp_value),
      .rsp_consumed (rsp_consumed)
   );

endmodule

// ===== src/rilp_checker.sv =====
// port-level checks on the result channel of the literal parser
// depends on rilp_pkg; bound to radix_integer_literal_parser_unit
`timescale 1ns / 1ps

module rilp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_status,
   input logic signed [rilp_pkg::VALUE_W-1:0] rsp_value,
   input logic [rilp_pkg::COUNT_W-1:0]        rsp_consumed
);
   import rilp_pkg::*;

   // stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status)
         && $stable(rsp_consumed))
      else $error("stalled result word changed");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // invalid literal reports zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_BAD) |-> rsp_value == '0)
      else $error("invalid literal with nonzero value");

   // a negative value needs a sign and at least one digit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_OK) && rsp_value[VALUE_W-1]
         |-> rsp_consumed >= COUNT_W'(2))
      else $error("negative value with too few characters");

endmodule

bind radix_integer_literal_parser_unit rilp_checker u_rilp_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_status   (rsp_status),
   .rsp_value    (rsp_value),
   .rsp_consumed (rsp_consumed)
);
